[hdl/pdsu_pkg.sv]
`default_nettype none
package pdsu_pkg;

	localparam int PASS_IDX_W = 5;
	localparam int RES_IDX_W  = 6;
	localparam int KEY_IN_W   = 16;
	localparam int POS_W      = 5;

	localparam logic [1:0] OP_KEY = 2'd0;
	localparam logic [1:0] OP_USE = 2'd1;
	localparam logic [1:0] OP_RUN = 2'd2;

	localparam logic [1:0] REG_PASS_COUNT    = 2'd0;
	localparam logic [1:0] REG_TEXTURE_COUNT = 2'd1;
	localparam logic [1:0] REG_BUFFER_COUNT  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_USE,
		S_CNT,
		S_SEL,
		S_UPD,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic key_wr;
		logic use_rd;
		logic use_wr;
		logic clr;
		logic run_init;
		logic cnt_step;
		logic sel_clr;
		logic sel_step;
		logic upd;
		logic mark_cyc;
		logic emit_step;
	} ctl_cmd_t;

	typedef struct packed {
		logic use_ok;
		logic n_zero;
		logic idx_last;
		logic found;
		logic sched_full;
		logic emit_last;
	} dp_sts_t;

endpackage
`default_nettype wire

[hdl/pdsu_ram.sv]
`default_nettype none
module pdsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[hdl/pdsu_ctrl.sv]
`default_nettype none
module pdsu_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic [1:0]          in_op,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire pdsu_pkg::dp_sts_t   sts,
	output pdsu_pkg::ctl_cmd_t       cmd
);

	pdsu_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdsu_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			pdsu_pkg::S_IDLE: begin
				if (in_valid && in_op == pdsu_pkg::OP_USE && sts.use_ok) begin
					state_nx = pdsu_pkg::S_USE;
				end else if (in_valid && in_op == pdsu_pkg::OP_RUN && !sts.n_zero) begin
					state_nx = pdsu_pkg::S_CNT;
				end
			end
			pdsu_pkg::S_USE: state_nx = pdsu_pkg::S_IDLE;
			pdsu_pkg::S_CNT: begin
				if (sts.idx_last) begin
					state_nx = pdsu_pkg::S_SEL;
				end
			end
			pdsu_pkg::S_SEL: begin
				if (sts.idx_last) begin
					state_nx = pdsu_pkg::S_UPD;
				end
			end
			pdsu_pkg::S_UPD: begin
				if (!sts.found || sts.sched_full) begin
					state_nx = pdsu_pkg::S_EMIT;
				end else begin
					state_nx = pdsu_pkg::S_SEL;
				end
			end
			pdsu_pkg::S_EMIT: begin
				if (out_ready && sts.emit_last) begin
					state_nx = pdsu_pkg::S_IDLE;
				end
			end
			default: state_nx = pdsu_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			pdsu_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_op)
						pdsu_pkg::OP_KEY: cmd.key_wr = 1'b1;
						pdsu_pkg::OP_USE: cmd.use_rd = sts.use_ok;
						pdsu_pkg::OP_RUN: begin
							cmd.clr      = sts.n_zero;
							cmd.run_init = !sts.n_zero;
						end
						default: cmd = '0;
					endcase
				end
			end
			pdsu_pkg::S_USE: cmd.use_wr = 1'b1;
			pdsu_pkg::S_CNT: begin
				cmd.cnt_step = 1'b1;
				cmd.sel_clr  = sts.idx_last;
			end
			pdsu_pkg::S_SEL: cmd.sel_step = 1'b1;
			pdsu_pkg::S_UPD: begin
				cmd.mark_cyc = !sts.found;
				cmd.upd      = sts.found;
				cmd.sel_clr  = 1'b1;
			end
			pdsu_pkg::S_EMIT: begin
				out_valid     = 1'b1;
				cmd.emit_step = out_ready;
				cmd.clr       = out_ready && sts.emit_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

[hdl/pdsu_dp.sv]
`default_nettype none
module pdsu_dp #(
	parameter int MAX_PASSES   = 32,
	parameter int MAX_TEXTURES = 64,
	parameter int MAX_BUFFERS  = 32,
	parameter int KEY_BITS     = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pdsu_pkg::ctl_cmd_t                  cmd,
	output pdsu_pkg::dp_sts_t                        sts,
	input  wire logic [5:0]                          pass_count,
	input  wire logic [6:0]                          texture_count,
	input  wire logic [5:0]                          buffer_count,
	input  wire logic [pdsu_pkg::PASS_IDX_W-1:0]     in_pass,
	input  wire logic [pdsu_pkg::RES_IDX_W-1:0]      in_res,
	input  wire logic                                in_buf,
	input  wire logic                                in_wr,
	input  wire logic [pdsu_pkg::KEY_IN_W-1:0]       in_key,
	output logic      [pdsu_pkg::PASS_IDX_W-1:0]     out_pass,
	output logic      [pdsu_pkg::POS_W-1:0]          out_pos,
	output logic                                     out_cycle,
	output logic                                     out_last
);

	localparam int PW  = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;
	localparam int CW  = $clog2(MAX_PASSES + 1);
	localparam int TAW = (MAX_TEXTURES > 1) ? $clog2(MAX_TEXTURES) : 1;
	localparam int BAW = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;

	logic [6:0]    pc7, n7;
	logic [CW-1:0] n_eff;
	logic          pass_ok, tex_ok, buf_ok;
	logic [8:0]    res9;
	logic [31:0]   key32;

	assign pc7   = {1'b0, pass_count};
	assign n7    = (pc7 > 7'(MAX_PASSES)) ? 7'(MAX_PASSES) : pc7;
	assign n_eff = CW'(n7);
	assign res9  = {3'b0, in_res};
	assign key32 = {16'b0, in_key};

	assign pass_ok = {2'b0, in_pass} < n7;
	assign tex_ok  = (res9 < {2'b0, texture_count}) && (res9 < 9'(MAX_TEXTURES));
	assign buf_ok  = (res9 < {3'b0, buffer_count}) && (res9 < 9'(MAX_BUFFERS));

	logic [PW-1:0]  p_idx;
	logic [TAW-1:0] in_taddr;
	logic [BAW-1:0] in_baddr;
	assign p_idx    = PW'(in_pass);
	assign in_taddr = TAW'(res9);
	assign in_baddr = BAW'(res9);

	// use tracking
	logic [PW-1:0]  p_q;
	logic           wr_q, buf_q;
	logic [TAW-1:0] taddr_q;
	logic [BAW-1:0] baddr_q;

	logic [MAX_TEXTURES-1:0] tex_lwv_q, tex_lav_q;
	logic [MAX_BUFFERS-1:0]  buf_lwv_q, buf_lav_q;

	logic [2*PW-1:0] tex_rdata, buf_rdata, entry, new_entry;
	logic            lwv, lav, add_en;
	logic [PW-1:0]   lw_old, la_old, add_from;

	assign entry     = buf_q ? buf_rdata : tex_rdata;
	assign lw_old    = entry[2*PW-1:PW];
	assign la_old    = entry[PW-1:0];
	assign lwv       = buf_q ? buf_lwv_q[baddr_q] : tex_lwv_q[taddr_q];
	assign lav       = buf_q ? buf_lav_q[baddr_q] : tex_lav_q[taddr_q];
	assign add_en    = wr_q ? lav : lwv;
	assign add_from  = wr_q ? la_old : lw_old;
	assign new_entry = {(wr_q ? p_q : lw_old), p_q};

	pdsu_ram #(.WIDTH(2*PW), .DEPTH(MAX_TEXTURES)) u_tex_ram (
		.clk   (clk),
		.we    (cmd.use_wr && !buf_q),
		.waddr (taddr_q),
		.wdata (new_entry),
		.raddr (in_taddr),
		.rdata (tex_rdata)
	);

	pdsu_ram #(.WIDTH(2*PW), .DEPTH(MAX_BUFFERS)) u_buf_ram (
		.clk   (clk),
		.we    (cmd.use_wr && buf_q),
		.waddr (baddr_q),
		.wdata (new_entry),
		.raddr (in_baddr),
		.rdata (buf_rdata)
	);

	// scheduling state
	logic [MAX_PASSES-1:0] adj_q [MAX_PASSES];
	logic [MAX_PASSES-1:0] done_q, vmask, row_sel;
	logic [KEY_BITS-1:0]   key_q [MAX_PASSES];
	logic [CW-1:0]         indeg_q [MAX_PASSES];
	logic [PW-1:0]         order_q [MAX_PASSES];
	logic [PW-1:0]         idx_q, best_q, pos_q;
	logic [KEY_BITS-1:0]   best_key_q;
	logic [CW-1:0]         cnt_q;
	logic                  found_q, cyc_q, rdy;

	always_comb begin
		for (int v = 0; v < MAX_PASSES; v++) begin
			vmask[v] = CW'(v) < n_eff;
		end
	end

	assign row_sel = adj_q[cmd.cnt_step ? idx_q : best_q] & vmask;
	assign rdy     = !done_q[idx_q] && (indeg_q[idx_q] == '0);

	assign sts.use_ok     = pass_ok && (in_buf ? buf_ok : tex_ok);
	assign sts.n_zero     = n_eff == '0;
	assign sts.idx_last   = (CW'(idx_q) + CW'(1)) == n_eff;
	assign sts.found      = found_q;
	assign sts.sched_full = (cnt_q + CW'(1)) == n_eff;
	assign sts.emit_last  = cyc_q || ((CW'(pos_q) + CW'(1)) == n_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int u = 0; u < MAX_PASSES; u++) begin
				adj_q[u] <= '0;
			end
			tex_lwv_q <= '0;
			tex_lav_q <= '0;
			buf_lwv_q <= '0;
			buf_lav_q <= '0;
			done_q    <= '0;
			found_q   <= 1'b0;
			cyc_q     <= 1'b0;
			idx_q     <= '0;
			cnt_q     <= '0;
			pos_q     <= '0;
		end else begin
			if (cmd.use_wr) begin
				if (add_en) begin
					adj_q[add_from][p_q] <= 1'b1;
				end
				if (buf_q) begin
					buf_lav_q[baddr_q] <= 1'b1;
					if (wr_q) begin
						buf_lwv_q[baddr_q] <= 1'b1;
					end
				end else begin
					tex_lav_q[taddr_q] <= 1'b1;
					if (wr_q) begin
						tex_lwv_q[taddr_q] <= 1'b1;
					end
				end
			end
			if (cmd.run_init) begin
				done_q <= '0;
				cyc_q  <= 1'b0;
				idx_q  <= '0;
				cnt_q  <= '0;
				pos_q  <= '0;
			end
			if (cmd.cnt_step || cmd.sel_step) begin
				idx_q <= sts.idx_last ? '0 : idx_q + PW'(1);
			end
			if (cmd.sel_clr) begin
				found_q <= 1'b0;
			end
			if (cmd.sel_step && rdy && (!found_q || key_q[idx_q] < best_key_q)) begin
				found_q <= 1'b1;
			end
			if (cmd.upd) begin
				done_q[best_q] <= 1'b1;
				cnt_q          <= cnt_q + CW'(1);
			end
			if (cmd.mark_cyc) begin
				cyc_q <= 1'b1;
			end
			if (cmd.emit_step) begin
				pos_q <= pos_q + PW'(1);
			end
			if (cmd.clr) begin
				for (int u = 0; u < MAX_PASSES; u++) begin
					adj_q[u] <= '0;
				end
				tex_lwv_q <= '0;
				tex_lav_q <= '0;
				buf_lwv_q <= '0;
				buf_lav_q <= '0;
				done_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.use_rd) begin
			p_q     <= p_idx;
			wr_q    <= in_wr;
			buf_q   <= in_buf;
			taddr_q <= in_taddr;
			baddr_q <= in_baddr;
		end
		if (cmd.key_wr && pass_ok) begin
			key_q[p_idx] <= key32[KEY_BITS-1:0];
		end
		for (int v = 0; v < MAX_PASSES; v++) begin
			if (cmd.run_init) begin
				indeg_q[v] <= '0;
			end else if (cmd.cnt_step && row_sel[v]) begin
				indeg_q[v] <= indeg_q[v] + CW'(1);
			end else if (cmd.upd && row_sel[v]) begin
				indeg_q[v] <= indeg_q[v] - CW'(1);
			end
		end
		if (cmd.sel_step && rdy && (!found_q || key_q[idx_q] < best_key_q)) begin
			best_q     <= idx_q;
			best_key_q <= key_q[idx_q];
		end
		if (cmd.upd) begin
			order_q[cnt_q[PW-1:0]] <= best_q;
		end
	end

	assign out_cycle = cyc_q;
	assign out_last  = sts.emit_last;
	assign out_pass  = cyc_q ? '0 : pdsu_pkg::PASS_IDX_W'(order_q[pos_q]);
	assign out_pos   = cyc_q ? '0 : pdsu_pkg::POS_W'(pos_q);

endmodule
`default_nettype wire

[hdl/pass_dependency_scheduler_unit.sv]
`default_nettype none
// channel     | direction | contents
// s_axis      | in        | key writes, resource uses, run commands (one per transaction)
// m_axis      | out       | scheduled passes in order, tlast on the final one
// apb         | in        | pass_count @0x0, texture_count @0x4, buffer_count @0x8
//
// a key write is stored while idle; a resource use reads the table, then updates it
// a run for n passes first does an indegree sweep over the
// edge rows, then one key scan per scheduled pass; results then leave at one
// per cycle while m_axis_tready is high
// arst_n clears the config and control registers, edges and resource table valid bits at once
// s_axis_tready is low while a use, a run or its results are in progress
module pass_dependency_scheduler_unit #(
	parameter int MAX_PASSES   = 32,
	parameter int MAX_TEXTURES = 64,
	parameter int MAX_BUFFERS  = 32,
	parameter int KEY_BITS     = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// pass_index[4:0], resource_index[10:5], is_buffer[11], is_write[12],
	// order_key[28:13]
	input  wire logic [31:0] s_axis_tdata,
	// opcode[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// scheduled_pass[4:0], position[9:5]
	output logic      [15:0] m_axis_tdata,
	// cycle_found[0]
	output logic      [0:0]  m_axis_tuser,
	output logic             m_axis_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic [5:0] pass_count_q;
	logic [6:0] texture_count_q;
	logic [5:0] buffer_count_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_count_q    <= '0;
			texture_count_q <= '0;
			buffer_count_q  <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				pdsu_pkg::REG_PASS_COUNT:    pass_count_q    <= pwdata[5:0];
				pdsu_pkg::REG_TEXTURE_COUNT: texture_count_q <= pwdata[6:0];
				pdsu_pkg::REG_BUFFER_COUNT:  buffer_count_q  <= pwdata[5:0];
				default: pass_count_q <= pass_count_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			pdsu_pkg::REG_PASS_COUNT:    prdata = {26'b0, pass_count_q};
			pdsu_pkg::REG_TEXTURE_COUNT: prdata = {25'b0, texture_count_q};
			pdsu_pkg::REG_BUFFER_COUNT:  prdata = {26'b0, buffer_count_q};
			default:                     prdata = '0;
		endcase
	end

	pdsu_pkg::ctl_cmd_t cmd;
	pdsu_pkg::dp_sts_t  sts;
	logic [4:0]         out_pass, out_pos;
	logic               out_cycle;

	pdsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_op     (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pdsu_dp #(
		.MAX_PASSES   (MAX_PASSES),
		.MAX_TEXTURES (MAX_TEXTURES),
		.MAX_BUFFERS  (MAX_BUFFERS),
		.KEY_BITS     (KEY_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.pass_count    (pass_count_q),
		.texture_count (texture_count_q),
		.buffer_count  (buffer_count_q),
		.in_pass       (s_axis_tdata[4:0]),
		.in_res        (s_axis_tdata[10:5]),
		.in_buf        (s_axis_tdata[11]),
		.in_wr         (s_axis_tdata[12]),
		.in_key        (s_axis_tdata[28:13]),
		.out_pass      (out_pass),
		.out_pos       (out_pos),
		.out_cycle     (out_cycle),
		.out_last      (m_axis_tlast)
	);

	assign m_axis_tdata = {6'b0, out_pos, out_pass};
	assign m_axis_tuser = out_cycle;

`ifndef SYNTH
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("input taken while results pending");

	a_cycle_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == 16'd0)
		else $error("cycle result malformed");

	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("not idle after final result");
`endif

endmodule
`default_nettype wire

[tb/pdsu_checker.sv]
`timescale 1ns / 1ps
module pdsu_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,
	input  wire logic [1:0]  s_axis_tuser,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [15:0] m_axis_tdata,
	input  wire logic [0:0]  m_axis_tuser,
	input  wire logic        m_axis_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic [4:0] pass;
		logic [4:0] pos;
		logic       cyc;
		logic       last;
	} sched_t;

	sched_t      sched_q[$];
	logic [5:0]  n_pass;
	logic [6:0]  n_tex;
	logic [5:0]  n_buf;
	logic [4:0]  tex_wr[64], tex_acc[64], buf_wr[32], buf_acc[32];
	logic        tex_wv[64], tex_av[64], buf_wv[32], buf_av[32];
	logic [31:0] succ[32];
	logic [15:0] keys[32];

	assign pending = sched_q.size();

	task automatic clear_graph();
		for (int i = 0; i < 64; i++) begin
			tex_wv[i] = 0;
			tex_av[i] = 0;
		end
		for (int i = 0; i < 32; i++) begin
			buf_wv[i] = 0;
			buf_av[i] = 0;
			succ[i] = '0;
		end
	endtask

	task automatic run_sort();
		int          n, cnt, best;
		logic [31:0] pred[32];
		logic [31:0] done;
		logic [4:0]  order[32];
		logic        found;
		sched_t      r;
		n = (n_pass > 32) ? 32 : n_pass;
		cnt = 0;
		done = '0;
		if (n != 0) begin
			for (int v = 0; v < n; v++) begin
				pred[v] = '0;
				for (int u = 0; u < n; u++)
					if (succ[u][v]) pred[v][u] = 1'b1;
			end
			while (cnt < n) begin
				found = 0;
				best = 0;
				for (int v = 0; v < n; v++)
					if (!done[v] && (pred[v] & ~done) == 0)
						if (!found || keys[v] < keys[best]) begin
							best = v;
							found = 1;
						end
				if (!found) break;
				done[best] = 1'b1;
				order[cnt] = best[4:0];
				cnt++;
			end
			if (cnt != n) begin
				r = '{pass: 5'd0, pos: 5'd0, cyc: 1'b1, last: 1'b1};
				sched_q = {sched_q, r};
			end else
				for (int u = 0; u < cnt; u++) begin
					r = '{pass: order[u], pos: u[4:0], cyc: 1'b0, last: (u + 1 == cnt)};
					sched_q = {sched_q, r};
				end
		end
		clear_graph();
	endtask

	task automatic apply_item(logic [1:0] op, logic [31:0] d);
		logic [4:0] p, lw, la;
		logic [5:0] res;
		logic       wr, lwv, lav;
		int         n, lim;
		p = d[4:0];
		res = d[10:5];
		wr = d[12];
		n = (n_pass > 32) ? 32 : n_pass;
		if (op == pdsu_pkg::OP_KEY) begin
			if (p < n) keys[p] = d[28:13];
		end else if (op == pdsu_pkg::OP_USE && p < n) begin
			lim = d[11] ? ((n_buf > 32) ? 32 : n_buf) : ((n_tex > 64) ? 64 : n_tex);
			if (res < lim) begin
				if (d[11]) begin
					lw = buf_wr[res]; lwv = buf_wv[res]; la = buf_acc[res]; lav = buf_av[res];
				end else begin
					lw = tex_wr[res]; lwv = tex_wv[res]; la = tex_acc[res]; lav = tex_av[res];
				end
				if (wr) begin
					if (lav) succ[la][p] = 1'b1;
					lw = p;
					lwv = 1;
				end else if (lwv)
					succ[lw][p] = 1'b1;
				la = p;
				lav = 1;
				if (d[11]) begin
					buf_wr[res] = lw; buf_wv[res] = lwv; buf_acc[res] = la; buf_av[res] = lav;
				end else begin
					tex_wr[res] = lw; tex_wv[res] = lwv; tex_acc[res] = la; tex_av[res] = lav;
				end
			end
		end else if (op == pdsu_pkg::OP_RUN)
			run_sort();
	endtask

	always @(posedge clk or negedge arst_n) begin
		sched_t got, want;
		if (!arst_n) begin
			fail_count <= 0;
			n_pass = 0;
			n_tex = 0;
			n_buf = 0;
			sched_q.delete();
			for (int i = 0; i < 32; i++) keys[i] = '0;
			clear_graph();
		end else begin
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
				pdsu_pkg::REG_PASS_COUNT:    n_pass = pwdata[5:0];
				pdsu_pkg::REG_TEXTURE_COUNT: n_tex = pwdata[6:0];
				pdsu_pkg::REG_BUFFER_COUNT:  n_buf = pwdata[5:0];
				default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				apply_item(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{pass: m_axis_tdata[4:0], pos: m_axis_tdata[9:5],
					cyc: m_axis_tuser[0], last: m_axis_tlast};
				if (sched_q.size() == 0) begin
					$display("%0t unexpected result: expected none, actual %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = sched_q.pop_front();
					if (got !== want) begin
						$display({"%0t mismatch: expected pass %0d pos %0d cyc %0d last %0d,",
							" actual pass %0d pos %0d cyc %0d last %0d"},
							$time, want.pass, want.pos, want.cyc, want.last,
							got.pass, got.pos, got.cyc, got.last);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

[tb/tb_pass_dependency_scheduler_unit.sv]
`timescale 1ns / 1ps
module tb_pass_dependency_scheduler_unit;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [15:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count, pending;
	int          idle_cycles = 0;
	logic        rx_busy;
	logic [5:0]  cur_passes;

	always #1 clk = ~clk;

	pass_dependency_scheduler_unit u_dut (.*);

	pdsu_checker u_chk (.*);

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver stalls at random, with calm stretches
	initial begin
		int w;
		forever begin
			@(posedge clk);
			if (rx_busy) begin
				w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
				if (w != 0) begin
					m_axis_tready <= 0;
					repeat (w) @(posedge clk);
				end
				m_axis_tready <= 1;
				do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
				m_axis_tready <= 0;
			end else
				m_axis_tready <= 1;
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] v);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		@(posedge clk);
		if (idx == pdsu_pkg::REG_PASS_COUNT) cur_passes = v[5:0];
	endtask

	task automatic send(logic [1:0] op, logic [4:0] p, logic [5:0] res,
			logic buf_use, logic wr, logic [15:0] k);
		int w;
		w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
		if (w != 0) begin
			s_axis_tvalid <= 0;
			repeat (w) @(posedge clk);
		end
		s_axis_tuser <= op;
		s_axis_tdata <= {3'b0, k, wr, buf_use, res, p};
		s_axis_tvalid <= 1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	// keys for every pass, random uses, then a run
	task automatic frame(int uses, int hazard_span);
		for (int p = 0; p < cur_passes && p < 32; p++)
			send(pdsu_pkg::OP_KEY, 5'(p), '0, 1'($urandom), 1'($urandom),
				($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom));
		for (int i = 0, p = 0; i < uses; i++) begin
			if ($urandom_range(0, 3) == 0 && p < 31) p++;
			if ($urandom_range(0, 9) == 0)
				send(($urandom_range(0, 3) == 0) ? 2'd3 : pdsu_pkg::OP_USE, 5'($urandom),
					6'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
			else
				send(pdsu_pkg::OP_USE, 5'(p), 6'($urandom_range(0, hazard_span)),
					1'($urandom), 1'($urandom), 16'($urandom));
		end
		send(pdsu_pkg::OP_RUN, 5'($urandom), 6'($urandom), 1'($urandom), 1'($urandom),
			16'($urandom));
	endtask

	initial begin
		int n;
		rx_busy = 0;
		cur_passes = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		rx_busy = 1;
		// empty graph emits nothing
		send(pdsu_pkg::OP_RUN, 0, 0, 0, 0, 0);
		drain();
		reg_write(pdsu_pkg::REG_PASS_COUNT, 4);
		reg_write(pdsu_pkg::REG_TEXTURE_COUNT, 64);
		reg_write(pdsu_pkg::REG_BUFFER_COUNT, 32);
		send(pdsu_pkg::OP_KEY, 0, 0, 0, 0, 16'hffff);
		send(pdsu_pkg::OP_KEY, 1, 0, 0, 0, 16'h0000);
		send(pdsu_pkg::OP_KEY, 2, 0, 0, 0, 16'h0000);
		send(pdsu_pkg::OP_KEY, 3, 0, 0, 0, 16'h0005);
		send(pdsu_pkg::OP_KEY, 31, 0, 0, 0, 16'h1234);
		send(pdsu_pkg::OP_USE, 0, 63, 0, 1, 0);
		send(pdsu_pkg::OP_USE, 2, 63, 0, 0, 0);
		send(pdsu_pkg::OP_USE, 1, 31, 1, 1, 0);
		send(pdsu_pkg::OP_USE, 3, 31, 1, 1, 0);
		send(pdsu_pkg::OP_USE, 31, 5, 1, 1, 0);
		send(2'd3, 3, 0, 0, 0, 0);
		send(pdsu_pkg::OP_RUN, 0, 0, 0, 0, 0);
		drain();
		// self edge, then a cycle
		send(pdsu_pkg::OP_USE, 1, 0, 0, 1, 0);
		send(pdsu_pkg::OP_USE, 1, 0, 0, 0, 0);
		send(pdsu_pkg::OP_RUN, 0, 0, 0, 0, 0);
		send(pdsu_pkg::OP_USE, 0, 1, 1, 1, 0);
		send(pdsu_pkg::OP_USE, 2, 1, 1, 0, 0);
		send(pdsu_pkg::OP_USE, 0, 1, 1, 1, 0);
		send(pdsu_pkg::OP_RUN, 0, 0, 0, 0, 0);
		drain();
		reg_write(pdsu_pkg::REG_TEXTURE_COUNT, 0);
		reg_write(pdsu_pkg::REG_BUFFER_COUNT, 0);
		send(pdsu_pkg::OP_USE, 0, 0, 0, 1, 0);
		send(pdsu_pkg::OP_USE, 0, 0, 1, 1, 0);
		send(pdsu_pkg::OP_RUN, 0, 0, 0, 0, 0);
		drain();
		reg_write(pdsu_pkg::REG_PASS_COUNT, 32);
		reg_write(pdsu_pkg::REG_TEXTURE_COUNT, 64);
		reg_write(pdsu_pkg::REG_BUFFER_COUNT, 32);
		frame(40, 63);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			n = (ph == 3) ? 32 : $urandom_range(1, 10);
			reg_write(pdsu_pkg::REG_PASS_COUNT, (ph == 2) ? 63 : n);
			reg_write(pdsu_pkg::REG_TEXTURE_COUNT, $urandom_range(0, 127));
			reg_write(pdsu_pkg::REG_BUFFER_COUNT, $urandom_range(0, 63));
			for (int f = 0; f < 2; f++)
				frame($urandom_range(4, 14), $urandom_range(1, 8));
			drain();
		end
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
